// ----- rtl/http_byte_range_parser_assert.svh -----
// Assertion macros for the HTTP byte-range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define HBRP_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbrp assertion failed");
`define HBRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbrp assertion failed");
`else
`define HBRP_ASSERT(label, ante, cons)
`define HBRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/hbrp_pkg.sv -----
// Shared types, codes and constants of the HTTP byte-range parser.
`default_nettype none
package hbrp_pkg;
	localparam int VALUE_W = 64;
	localparam logic [VALUE_W-1:0] VMASK = '1;
	localparam logic [VALUE_W-1:0] MAX_TEN = VMASK / 10;
	localparam logic [3:0] MAX_DIG = 4'(VMASK % 10);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGES = 1'b1;
	localparam logic [7:0] MAX_RANGES_RST = 8'd100;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_END = 1'b1;
	localparam logic KIND_RANGE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_INVALID = 2'd1;
	localparam logic [1:0] ERR_UNSAT = 2'd2;

	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_UNSAT = 2'd1;
	localparam logic [1:0] ST_SINGLE = 2'd2;
	localparam logic [1:0] ST_MULTI = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [2:0] PREFIX_LAST = 3'd5;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic        out_kind;
		logic [63:0] range_first;
		logic [63:0] range_limit;
		logic [1:0]  parse_status;
		logic        is_last;
	} rsp_t;

	typedef struct packed {
		logic               is_end;
		logic               do_close;
		logic               open_spec;
		logic               suffix;
		logic [1:0]         err;
		logic [VALUE_W-1:0] first;
		logic [VALUE_W-1:0] second;
	} cmd_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [63:0]          data;
	} cfg_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h62;
			3'd1: c = 8'h79;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h73;
			3'd5: c = 8'h3d;
			default: c = 8'hff;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/hbrp_front.sv -----
// Front end: character scanner that turns header items into commands.
`default_nettype none
module hbrp_front import hbrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_fire,
	output cmd_t cmd,
	output logic cmd_push
);
	localparam logic [3:0] PH_PREFIX = 4'd0;
	localparam logic [3:0] PH_LEAD = 4'd1;
	localparam logic [3:0] PH_FIRST = 4'd2;
	localparam logic [3:0] PH_FIRST_WS = 4'd3;
	localparam logic [3:0] PH_AFTER_DASH = 4'd4;
	localparam logic [3:0] PH_NEED_SECOND = 4'd5;
	localparam logic [3:0] PH_SECOND = 4'd6;
	localparam logic [3:0] PH_SECOND_WS = 4'd7;
	localparam logic [3:0] PH_DONE = 4'd8;

	logic [3:0]         phase_q, phase_n;
	logic [2:0]         prefix_pos_q, prefix_pos_n;
	logic [VALUE_W-1:0] first_q, first_n;
	logic [VALUE_W-1:0] second_q, second_n;
	logic               suffix_q, suffix_n;
	logic               stop_q, stop_n;

	logic [7:0]         c;
	logic               is_dig;
	logic [3:0]         digit;
	logic               use_second;
	logic [VALUE_W-1:0] acc_sel;
	logic               acc_ovf;
	logic [VALUE_W-1:0] acc_next;
	logic               dig_add;
	logic               term_close;
	logic               active;

	assign c = req.char_code;
	assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit = is_dig ? 4'(c - CH_ZERO) : 4'd0;
	assign use_second = (phase_q == PH_AFTER_DASH) || (phase_q == PH_NEED_SECOND) ||
		(phase_q == PH_SECOND);
	assign acc_sel = use_second ? second_q : first_q;
	assign acc_ovf = (acc_sel > MAX_TEN) || ((acc_sel == MAX_TEN) && (digit > MAX_DIG));
	assign acc_next = (acc_sel << 3) + (acc_sel << 1) + VALUE_W'(digit);
	assign term_close = (phase_q == PH_AFTER_DASH) || (phase_q == PH_SECOND) ||
		(phase_q == PH_SECOND_WS);
	assign active = !stop_q && (phase_q != PH_DONE);

	always_comb begin
		phase_n = phase_q;
		prefix_pos_n = prefix_pos_q;
		first_n = first_q;
		second_n = second_q;
		suffix_n = suffix_q;
		stop_n = stop_q;
		dig_add = 1'b0;
		cmd = '0;
		cmd.first = first_q;
		cmd.second = second_q;
		cmd.suffix = suffix_q;
		cmd_push = 1'b0;
		if (req_fire) begin
			if (req.req_type == REQ_END) begin
				cmd.is_end = 1'b1;
				cmd_push = 1'b1;
				if (active) begin
					if (term_close) begin
						cmd.do_close = 1'b1;
						cmd.open_spec = (phase_q == PH_AFTER_DASH);
					end else begin
						cmd.err = ERR_INVALID;
					end
				end
				phase_n = PH_PREFIX;
				prefix_pos_n = '0;
				first_n = '0;
				second_n = '0;
				suffix_n = 1'b0;
				stop_n = 1'b0;
			end else if (active) begin
				if (phase_q == PH_PREFIX) begin
					if (c == prefix_char(prefix_pos_q)) begin
						prefix_pos_n = prefix_pos_q + 3'd1;
						if (prefix_pos_q == PREFIX_LAST) begin
							phase_n = PH_LEAD;
						end
					end else begin
						stop_n = 1'b1;
						cmd.err = ERR_INVALID;
						cmd_push = 1'b1;
					end
				end else if (c == CH_NUL) begin
					phase_n = PH_DONE;
					if (term_close) begin
						cmd.do_close = 1'b1;
						cmd.open_spec = (phase_q == PH_AFTER_DASH);
					end else begin
						stop_n = 1'b1;
						cmd.err = ERR_INVALID;
					end
					cmd_push = 1'b1;
				end else begin
					case (phase_q)
						PH_LEAD: begin
							if (c == CH_SPACE) begin
							end else if (c == CH_DASH) begin
								suffix_n = 1'b1;
								phase_n = PH_NEED_SECOND;
							end else if (is_dig) begin
								dig_add = 1'b1;
								phase_n = PH_FIRST;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_FIRST: begin
							if (is_dig) begin
								dig_add = 1'b1;
							end else if (c == CH_SPACE) begin
								phase_n = PH_FIRST_WS;
							end else if (c == CH_DASH) begin
								phase_n = PH_AFTER_DASH;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_FIRST_WS: begin
							if (c == CH_SPACE) begin
							end else if (c == CH_DASH) begin
								phase_n = PH_AFTER_DASH;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_AFTER_DASH: begin
							if (c == CH_SPACE) begin
							end else if (c == CH_COMMA) begin
								cmd.do_close = 1'b1;
								cmd.open_spec = 1'b1;
								cmd_push = 1'b1;
							end else if (is_dig) begin
								dig_add = 1'b1;
								phase_n = PH_SECOND;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_NEED_SECOND: begin
							if (is_dig) begin
								dig_add = 1'b1;
								phase_n = PH_SECOND;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_SECOND: begin
							if (is_dig) begin
								dig_add = 1'b1;
							end else if (c == CH_SPACE) begin
								phase_n = PH_SECOND_WS;
							end else if (c == CH_COMMA) begin
								cmd.do_close = 1'b1;
								cmd_push = 1'b1;
							end else begin
								stop_n = 1'b1;
							end
						end
						PH_SECOND_WS: begin
							if (c == CH_SPACE) begin
							end else if (c == CH_COMMA) begin
								cmd.do_close = 1'b1;
								cmd_push = 1'b1;
							end else begin
								stop_n = 1'b1;
							end
						end
						default: begin
							stop_n = 1'b1;
						end
					endcase
					if (stop_n) begin
						cmd.err = ERR_INVALID;
						cmd_push = 1'b1;
					end else if (cmd.do_close) begin
						phase_n = PH_LEAD;
						first_n = '0;
						second_n = '0;
						suffix_n = 1'b0;
					end else if (dig_add) begin
						if (acc_ovf) begin
							stop_n = 1'b1;
							cmd.err = ERR_UNSAT;
							cmd_push = 1'b1;
						end else if (use_second) begin
							second_n = acc_next;
						end else begin
							first_n = acc_next;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			prefix_pos_q <= '0;
			first_q <= '0;
			second_q <= '0;
			suffix_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			prefix_pos_q <= prefix_pos_n;
			first_q <= first_n;
			second_q <= second_n;
			suffix_q <= suffix_n;
			stop_q <= stop_n;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hbrp_queue.sv -----
// Command queue between the scanner and the range unit.
`default_nettype none
module hbrp_queue import hbrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    din,
	input  logic    pop,
	output cmd_t    dout,
	output q_stat_t stat
);
	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign dout = mem_q[rd_ptr_q];
	assign stat.full = (count_q == Q_CW'(Q_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hbrp_back.sv -----
// Back end: clips specs, keeps totals and counts, and builds result items.
`default_nettype none
module hbrp_back import hbrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  cmd_t    head,
	input  q_stat_t q_stat,
	output logic    q_pop,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output rsp_t    rsp
);
	logic [VALUE_W-1:0] cl_q;
	logic [7:0]         max_ranges_q;

	logic               valid_s1;
	logic               end_s1, close_s1;
	logic [1:0]         err_s1;
	logic [VALUE_W-1:0] lo_s1, hi_s1;

	logic               valid_s2;
	logic               end_s2, close_s2, nonempty_s2;
	logic [1:0]         err_s2;
	logic [VALUE_W-1:0] lo_s2, hi_s2, len_s2;

	logic [VALUE_W-1:0] total_q;
	logic [7:0]         count_q;
	logic [1:0]         err_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               sec_lt_cl;
	logic [VALUE_W-1:0] lo_c, hi_c;
	logic               out_free, range_out, status_now, fire, consume;
	logic               s2_load, s1_adv, s1_load;
	logic [VALUE_W:0]   sum_w;
	logic [1:0]         eff_err;
	logic [1:0]         status_c;

	assign sec_lt_cl = head.second < cl_q;

	always_comb begin
		lo_c = head.first;
		hi_c = cl_q;
		if (!head.open_spec) begin
			if (head.suffix) begin
				lo_c = sec_lt_cl ? cl_q - head.second : '0;
			end else if (sec_lt_cl) begin
				hi_c = head.second + 1'b1;
			end
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign range_out = valid_s2 && close_s2 && nonempty_s2 && (err_q == ERR_NONE);
	assign status_now = valid_s2 && end_s2 && !range_out;
	assign fire = valid_s2 && (out_free || !(range_out || status_now));
	assign consume = fire && !(range_out && end_s2);
	assign s2_load = !valid_s2 || consume;
	assign s1_adv = valid_s1 && s2_load;
	assign s1_load = !valid_s1 || s1_adv;
	assign q_pop = !q_stat.empty && s1_load;

	assign sum_w = {1'b0, total_q} + {1'b0, len_s2};
	assign eff_err = (err_q != ERR_NONE) ? err_q : err_s2;

	always_comb begin
		if (eff_err == ERR_UNSAT) begin
			status_c = ST_UNSAT;
		end else if (eff_err == ERR_INVALID) begin
			status_c = ST_INVALID;
		end else if ((count_q == 8'd0) || (total_q > cl_q)) begin
			status_c = ST_UNSAT;
		end else if (count_q == 8'd1) begin
			status_c = ST_SINGLE;
		end else begin
			status_c = ST_MULTI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q <= '0;
			max_ranges_q <= MAX_RANGES_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				CFG_CONTENT_LENGTH: cl_q <= cfg.data[VALUE_W-1:0];
				CFG_MAX_RANGES: max_ranges_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= q_pop;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			end_s1 <= head.is_end;
			close_s1 <= head.do_close;
			err_s1 <= head.err;
			lo_s1 <= lo_c;
			hi_s1 <= hi_c;
		end
		if (s1_adv) begin
			end_s2 <= end_s1;
			close_s2 <= close_s1;
			err_s2 <= err_s1;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			nonempty_s2 <= lo_s1 < hi_s1;
			len_s2 <= hi_s1 - lo_s1;
		end else if (fire && range_out && end_s2) begin
			close_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			err_q <= ERR_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire && range_out) begin
				if (sum_w[VALUE_W]) begin
					err_q <= ERR_UNSAT;
				end else begin
					total_q <= sum_w[VALUE_W-1:0];
					if (count_q >= max_ranges_q) begin
						err_q <= ERR_INVALID;
					end else begin
						count_q <= count_q + 8'd1;
					end
				end
			end else if (fire && status_now) begin
				total_q <= '0;
				count_q <= '0;
				err_q <= ERR_NONE;
			end else if (fire && (err_q == ERR_NONE) && (err_s2 != ERR_NONE)) begin
				err_q <= err_s2;
			end
			if (fire && (range_out || status_now)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && range_out) begin
			rsp_q.out_kind <= KIND_RANGE;
			rsp_q.range_first <= 64'(lo_s2);
			rsp_q.range_limit <= 64'(hi_s2);
			rsp_q.parse_status <= ST_INVALID;
			rsp_q.is_last <= 1'b0;
		end else if (fire && status_now) begin
			rsp_q.out_kind <= KIND_STATUS;
			rsp_q.range_first <= '0;
			rsp_q.range_limit <= '0;
			rsp_q.parse_status <= status_c;
			rsp_q.is_last <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire

// ----- rtl/http_byte_range_parser.sv -----
// Top level of the HTTP byte-range header parser.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  req      | req_valid/req_ready   | req_t: req_type, char_code
//  rsp      | rsp_valid/rsp_ready   | rsp_t: kind, first, limit, status, last
//  cfg      | cfg_we (no wait)      | cfg_index, cfg_data
//
// One character item per cycle while req_ready is high; the scanner is combinational.
// A result passes the command queue, stages s1 and s2 and the output register.
// An end item that closes a non-empty, error-free spec gives two results (range, then status).
// A 4-entry command queue sits between scanner and range unit; req_ready drops when it fills.
// Reset clears parse state and sets content_length to 0 and max_ranges to 100.
`default_nettype none
module http_byte_range_parser import hbrp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);
`include "http_byte_range_parser_assert.svh"

	logic    req_fire;
	cmd_t    cmd;
	logic    cmd_push;
	cmd_t    head;
	logic    q_pop;
	q_stat_t q_stat;
	cfg_wr_t cfg;
	logic    rsp_is_range;

	assign req_ready = !q_stat.full;
	assign req_fire = req_valid && req_ready;
	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;
	assign rsp_is_range = rsp_valid && (rsp.out_kind == KIND_RANGE);

	hbrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_fire (req_fire),
		.cmd      (cmd),
		.cmd_push (cmd_push)
	);

	hbrp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.pop    (q_pop),
		.dout   (head),
		.stat   (q_stat)
	);

	hbrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`HBRP_ASSERT(a_no_q_overflow, cmd_push, !q_stat.full)
	`HBRP_ASSERT_NEXT(a_push_fills_q, cmd_push, !q_stat.empty)
	`HBRP_ASSERT(a_range_nonempty, rsp_is_range, rsp.range_first < rsp.range_limit)
	`HBRP_ASSERT(a_status_is_last, rsp_valid, rsp.is_last == rsp.out_kind)
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the HTTP byte-range header parser: directed headers, then random ones.
`default_nettype none
module tb_top;
	import hbrp_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 292;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TEN_CAP = ALL_ONES / 64'd10;
	localparam logic [3:0] DIG_CAP = 4'd5;
	localparam logic [47:0] PFX_TEXT = "bytes=";

	typedef enum logic [3:0] {
		SC_PREFIX, SC_LEAD, SC_FIRST, SC_FIRST_WS, SC_AFTER_DASH,
		SC_NEED_SECOND, SC_SECOND, SC_SECOND_WS, SC_DONE
	} scan_t;

	typedef struct {
		logic       rt;
		logic [7:0] ch;
		bit         typed;
		logic [1:0] st;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	// parser model state and register copies
	scan_t       scan;
	int unsigned pfx_pos;
	logic [63:0] num_a;
	logic [63:0] num_b;
	bit          is_suffix;
	logic [63:0] bytes_total;
	logic [7:0]  n_ranges;
	logic [1:0]  err_latch;
	logic [63:0] cl_cfg = 64'd0;
	logic [7:0]  mr_cfg = MAX_RANGES_RST;

	rsp_t       rsp_due[$];
	logic [7:0] hdr_q[$];
	dir_row_t   dir_tab[$];
	int         fails = 0;
	int         fed = 0;
	int         quiet = 0;
	int         snd_idle = 36;
	int         rcv_idle = 64;

	http_byte_range_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	function automatic void reset_scan();
		scan = SC_PREFIX;
		pfx_pos = 0;
		num_a = '0;
		num_b = '0;
		is_suffix = 1'b0;
		bytes_total = '0;
		n_ranges = '0;
		err_latch = ERR_NONE;
	endfunction

	function automatic void push_rsp(logic kind, logic [63:0] a, logic [63:0] b,
			logic [1:0] st, logic last);
		rsp_t r;
		r.out_kind = kind;
		r.range_first = a;
		r.range_limit = b;
		r.parse_status = st;
		r.is_last = last;
		rsp_due.insert(rsp_due.size(), r);
	endfunction

	function automatic logic [63:0] digit_in(logic [63:0] acc, logic [3:0] d);
		if (acc > TEN_CAP || (acc == TEN_CAP && d > DIG_CAP)) begin
			err_latch = ERR_UNSAT;
			return acc;
		end
		return acc * 64'd10 + 64'(d);
	endfunction

	function automatic void close_spec(bit open_end);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len;
		if (open_end) begin
			lo = num_a;
			hi = cl_cfg;
		end else begin
			hi = num_b;
			if (is_suffix) begin
				lo = (hi < cl_cfg) ? cl_cfg - hi : 64'd0;
				hi = cl_cfg - 64'd1;
			end else begin
				lo = num_a;
			end
			if (hi >= cl_cfg)
				hi = cl_cfg;
			else
				hi = hi + 64'd1;
		end
		if (lo < hi) begin
			push_rsp(KIND_RANGE, lo, hi, ST_INVALID, 1'b0);
			len = hi - lo;
			if (bytes_total > ~len) begin
				err_latch = ERR_UNSAT;
			end else begin
				bytes_total = bytes_total + len;
				if (n_ranges >= mr_cfg)
					err_latch = ERR_INVALID;
				else
					n_ranges = n_ranges + 8'd1;
			end
		end
	endfunction

	function automatic void next_spec();
		scan = SC_LEAD;
		num_a = '0;
		num_b = '0;
		is_suffix = 1'b0;
	endfunction

	function automatic void end_text();
		case (scan)
			SC_AFTER_DASH: close_spec(1'b1);
			SC_SECOND, SC_SECOND_WS: close_spec(1'b0);
			SC_DONE: ;
			default: err_latch = ERR_INVALID;
		endcase
		scan = SC_DONE;
	endfunction

	// returns 1 when the item is not simply ignored
	function automatic bit parse_step(req_t r);
		logic [7:0] c;
		logic [7:0] diff;
		logic [3:0] d;
		bit         dig;
		logic [1:0] st;
		c = r.char_code;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		diff = c - CH_ZERO;
		d = diff[3:0];
		if (r.req_type == REQ_END) begin
			if (err_latch == ERR_NONE && scan != SC_DONE)
				end_text();
			if (err_latch != ERR_NONE)
				st = (err_latch == ERR_UNSAT) ? ST_UNSAT : ST_INVALID;
			else if (n_ranges == 0 || bytes_total > cl_cfg)
				st = ST_UNSAT;
			else
				st = (n_ranges == 8'd1) ? ST_SINGLE : ST_MULTI;
			push_rsp(KIND_STATUS, '0, '0, st, 1'b1);
			reset_scan();
			return 1'b1;
		end
		if (err_latch != ERR_NONE || scan == SC_DONE)
			return 1'b0;
		if (scan == SC_PREFIX) begin
			if (pfx_pos < 6 && c == PFX_TEXT[47 - 8 * pfx_pos -: 8]) begin
				pfx_pos++;
				if (pfx_pos == 6)
					next_spec();
			end else begin
				err_latch = ERR_INVALID;
			end
			return 1'b1;
		end
		if (c == CH_NUL) begin
			end_text();
			return 1'b1;
		end
		case (scan)
			SC_LEAD: begin
				if (c == CH_SPACE) begin
				end else if (c == CH_DASH) begin
					is_suffix = 1'b1;
					scan = SC_NEED_SECOND;
				end else if (dig) begin
					num_a = digit_in(num_a, d);
					scan = SC_FIRST;
				end else begin
					err_latch = ERR_INVALID;
				end
			end
			SC_FIRST: begin
				if (dig) num_a = digit_in(num_a, d);
				else if (c == CH_SPACE) scan = SC_FIRST_WS;
				else if (c == CH_DASH) scan = SC_AFTER_DASH;
				else err_latch = ERR_INVALID;
			end
			SC_FIRST_WS: begin
				if (c == CH_SPACE) begin
				end else if (c == CH_DASH) scan = SC_AFTER_DASH;
				else err_latch = ERR_INVALID;
			end
			SC_AFTER_DASH: begin
				if (c == CH_SPACE) begin
				end else if (c == CH_COMMA) begin
					close_spec(1'b1);
					next_spec();
				end else if (dig) begin
					num_b = digit_in(num_b, d);
					scan = SC_SECOND;
				end else begin
					err_latch = ERR_INVALID;
				end
			end
			SC_NEED_SECOND: begin
				if (dig) begin
					num_b = digit_in(num_b, d);
					scan = SC_SECOND;
				end else begin
					err_latch = ERR_INVALID;
				end
			end
			SC_SECOND: begin
				if (dig) begin
					num_b = digit_in(num_b, d);
				end else if (c == CH_SPACE) begin
					scan = SC_SECOND_WS;
				end else if (c == CH_COMMA) begin
					close_spec(1'b0);
					next_spec();
				end else begin
					err_latch = ERR_INVALID;
				end
			end
			SC_SECOND_WS: begin
				if (c == CH_SPACE) begin
				end else if (c == CH_COMMA) begin
					close_spec(1'b0);
					next_spec();
				end else begin
					err_latch = ERR_INVALID;
				end
			end
			default: err_latch = ERR_INVALID;
		endcase
		return 1'b1;
	endfunction

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				$error("result with nothing expected: kind %0h status %0h", rsp.out_kind,
					rsp.parse_status);
				fails++;
			end else begin
				want = rsp_due.pop_front();
				if (rsp.out_kind !== want.out_kind) begin
					$error("out_kind: expected %0h, got %0h", want.out_kind, rsp.out_kind);
					fails++;
				end
				if (rsp.range_first !== want.range_first) begin
					$error("range_first: expected %0d, got %0d", want.range_first,
						rsp.range_first);
					fails++;
				end
				if (rsp.range_limit !== want.range_limit) begin
					$error("range_limit: expected %0d, got %0d", want.range_limit,
						rsp.range_limit);
					fails++;
				end
				if (rsp.parse_status !== want.parse_status) begin
					$error("parse_status: expected %0h, got %0h", want.parse_status,
						rsp.parse_status);
					fails++;
				end
				if (rsp.is_last !== want.is_last) begin
					$error("is_last: expected %0h, got %0h", want.is_last, rsp.is_last);
					fails++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic feed(input logic rt, input logic [7:0] ch);
		req_t r;
		bit   ok;
		r.req_type = rt;
		r.char_code = ch;
		while ($urandom_range(0, 99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			ok = req_ready;
			@(posedge clk);
		end while (!ok);
		void'(parse_step(r));
		fed++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (rsp_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [63:0] cl, input logic [7:0] mr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CONTENT_LENGTH;
		cfg_data <= cl;
		@(posedge clk);
		cfg_index <= CFG_MAX_RANGES;
		cfg_data <= {56'd0, mr};
		@(posedge clk);
		cfg_we <= 1'b0;
		cl_cfg = cl;
		mr_cfg = mr;
	endtask

	function automatic void add_row(logic rt, logic [7:0] ch, bit typed, logic [1:0] st);
		dir_row_t row;
		row.rt = rt;
		row.ch = ch;
		row.typed = typed;
		row.st = st;
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	function automatic void add_chars(string s);
		for (int i = 0; i < s.len(); i++)
			add_row(REQ_CHAR, s[i], 1'b0, ST_INVALID);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		hdr_q.insert(hdr_q.size(), b);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic string spaces();
		string s;
		int    n;
		s = "";
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) s = {s, " "};
		return s;
	endfunction

	function automatic string num_text();
		logic [63:0] v;
		int          sel;
		string       s;
		sel = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (sel < 30)
			v = 64'($urandom_range(0, 20));
		else if (sel < 55) begin
			if (cl_cfg < (64'd1 << 40))
				v = v % (cl_cfg + 64'd6);
		end else if (sel < 70)
			v = cl_cfg + 64'($urandom_range(0, 4)) - 64'd2;
		else if (sel < 85)
			v = v >> $urandom_range(0, 63);
		else if (sel < 93)
			v = ALL_ONES;
		if (sel >= 93) begin
			if ($urandom_range(0, 1))
				s = "18446744073709551616";
			else
				s = $sformatf("%0d%0d", v, $urandom_range(0, 9));
		end else
			s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0)
			s = {"0", s};
		return s;
	endfunction

	function automatic void make_header();
		string cs;
		int    style;
		int    n_spec;
		int    k;
		cs = "0123456789-, -,";
		hdr_q.delete();
		style = $urandom_range(0, 99);
		if (style < 10) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
			return;
		end
		put_text("bytes=");
		if (style < 20) begin
			repeat ($urandom_range(0, 14)) begin
				k = $urandom_range(0, cs.len());
				add_byte((k == cs.len()) ? CH_NUL : cs[k]);
			end
			return;
		end
		if ($urandom_range(0, 9) == 0)
			n_spec = $urandom_range(1, (mr_cfg < 8) ? mr_cfg + 2 : 10);
		else
			n_spec = $urandom_range(1, 3);
		for (int i = 0; i < n_spec; i++) begin
			if (i > 0)
				put_text(",");
			put_text(spaces());
			case ($urandom_range(0, 2))
				0: put_text({num_text(), spaces(), "-", spaces(), num_text(), spaces()});
				1: put_text({num_text(), spaces(), "-", spaces()});
				default: put_text({"-", num_text(), spaces()});
			endcase
		end
		if (style < 32) begin
			k = $urandom_range(6, hdr_q.size() - 1);
			case ($urandom_range(0, 4))
				0: add_byte(CH_COMMA);
				1: hdr_q.insert(k, CH_NUL);
				2: hdr_q.insert(k, 8'($urandom_range(0, 255)));
				3: hdr_q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
				default: hdr_q[k] = CH_COMMA;
			endcase
		end
		if ($urandom_range(0, 19) == 0) begin
			add_byte(CH_NUL);
			repeat ($urandom_range(0, 3)) add_byte(cs[$urandom_range(0, cs.len() - 1)]);
		end
	endfunction

	initial begin
		dir_row_t    row;
		rsp_t        tmp;
		logic [63:0] cl;
		logic [7:0]  mr;
		bit          paused;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CONTENT_LENGTH;
		cfg_data <= '0;
		reset_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: content length zero, range limit default
		add_row(REQ_END, 8'h00, 1'b1, ST_INVALID);
		add_row(REQ_CHAR, 8'hFF, 1'b0, ST_INVALID);
		add_row(REQ_END, 8'hFF, 1'b1, ST_INVALID);
		add_chars("bytes=");
		add_row(REQ_END, 8'h5A, 1'b1, ST_INVALID);
		add_chars("bytes=1-");
		add_row(REQ_END, 8'hA5, 1'b1, ST_UNSAT);
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			feed(row.rt, row.ch);
			if (row.typed) begin
				tmp = rsp_due.pop_back();
				tmp.parse_status = row.st;
				rsp_due.insert(rsp_due.size(), tmp);
			end
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin cl = 64'd1000; mr = 8'd3; end
				1: begin cl = ALL_ONES; mr = 8'd255; end
				2: begin cl = 64'd0; mr = 8'd1; end
				3: begin cl = 64'($urandom_range(1, 5000)); mr = 8'($urandom_range(1, 8)); end
				4: begin cl = {$urandom, $urandom}; mr = MAX_RANGES_RST; end
				default: begin cl = 64'd37; mr = 8'd2; end
			endcase
			snd_idle = (p < 2) ? 36 : (p < 4) ? 64 : 0;
			rcv_idle = (p < 2) ? 64 : (p < 4) ? 36 : 0;
			drain();
			write_regs(cl, mr);
			fed = 0;
			paused = 1'b0;
			while (fed < PHASE_ITEMS) begin
				make_header();
				foreach (hdr_q[i])
					feed(REQ_CHAR, hdr_q[i]);
				feed(REQ_END, 8'($urandom_range(0, 255)));
				if (!paused && fed > PHASE_ITEMS / 2) begin
					paused = 1'b1;
					req_valid <= 1'b0;
					do @(posedge clk); while (rsp_due.size() != 0);
				end
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (rsp_due.size() != 0) begin
			$error("%0d expected results never arrived", rsp_due.size());
			fails++;
		end
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
